// File: hw/rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared definitions for the preemptive priority scheduler
// Table sizing, field widths, codes, controller state, the command and status
// bundles between controller and datapath, and the time helper.
// ----------------------------------------------------------------------------
package pps_pkg;

   // Table size and derived widths
   localparam int MAX_TASKS  = 16;
   localparam int TASK_IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int TASK_CNT_W = $clog2(MAX_TASKS + 1);

   // Field widths fixed by the interface
   localparam int TIME_W     = 32;
   localparam int ARRIVAL_W  = 16;
   localparam int BURST_W    = 16;
   localparam int PRIO_W     = 8;
   localparam int TASK_NUM_W = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // Item kinds carried in req_tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // One table entry as held in the task RAM
   typedef struct packed {
      logic [ARRIVAL_W-1:0] arrival;
      logic [BURST_W-1:0]   remaining;
      logic [PRIO_W-1:0]    priority_num;
   } entry_type;

   // Request payload, lowest field in the lowest bits
   typedef struct packed {
      logic [PRIO_W-1:0]    task_priority;
      logic [BURST_W-1:0]   burst_length;
      logic [ARRIVAL_W-1:0] ready_tick;
   } req_payload_type;

   // Result payload, lowest field in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]     tick_time;
      logic                  load_error;
      logic                  all_done;
      logic [TIME_W-1:0]     finish_time;
      logic                  task_finished;
      logic [TASK_NUM_W-1:0] running_task;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_UPDATE,
      ST_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_en;
      logic tick_start;
      logic scan_step;
      logic update_en;
      logic out_load;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic table_empty;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   // Saturating increment of the time counter
   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
      return (v == TIME_MAX) ? v : v + TIME_W'(1);
   endfunction

endpackage

// File: hw/rtl/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl: scheduler controller
// Sequences load, scan, write-back and result hand-over for one item at a time.
// ----------------------------------------------------------------------------
module pps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_func,
   input  pps_pkg::dp_status_type status,
   output pps_pkg::ctrl_cmd_type  cmd
);

   pps_pkg::state_type state_ff;
   pps_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func == pps_pkg::FUNC_LOAD) begin
                  cmd.load_en = 1'b1;
                  state_in    = pps_pkg::ST_OUT;
               end else begin
                  cmd.tick_start = 1'b1;
                  state_in = status.table_empty ? pps_pkg::ST_UPDATE : pps_pkg::ST_SCAN;
               end
            end
         end
         pps_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = pps_pkg::ST_LAST;
            end
         end
         pps_pkg::ST_LAST: begin
            // The last entry's read data is compared in this cycle.
            state_in = pps_pkg::ST_UPDATE;
         end
         pps_pkg::ST_UPDATE: begin
            cmd.update_en = 1'b1;
            state_in      = pps_pkg::ST_OUT;
         end
         pps_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath: scheduler datapath
// Task RAM, done marks, counters, the scan comparator and the result register.
// ----------------------------------------------------------------------------
module pps_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pps_pkg::ctrl_cmd_type                cmd,
   input  logic [pps_pkg::ARRIVAL_W-1:0]        ready_tick,
   input  logic [pps_pkg::BURST_W-1:0]          burst_length,
   input  logic [pps_pkg::PRIO_W-1:0]           task_priority,
   output pps_pkg::dp_status_type               status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output pps_pkg::rsp_payload_type             rsp_payload
);

   localparam int IW = pps_pkg::TASK_IDX_W;
   localparam int CW = pps_pkg::TASK_CNT_W;
   localparam int TW = pps_pkg::TIME_W;

   // Control state
   logic [CW-1:0]                 entry_count_ff, entry_count_in;
   logic [CW-1:0]                 finished_count_ff, finished_count_in;
   logic [TW-1:0]                 time_ff, time_in;
   logic [pps_pkg::MAX_TASKS-1:0] done_ff, done_in;
   logic                          cmp_valid_ff, cmp_valid_in;
   logic                          found_ff, found_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [IW-1:0]                 scan_idx_ff, scan_idx_in;
   logic [IW-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]                 best_idx_ff, best_idx_in;
   pps_pkg::entry_type            best_ff, best_in;
   pps_pkg::rsp_payload_type      res_ff, res_in;
   pps_pkg::rsp_payload_type      rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   pps_pkg::entry_type            wr_data;
   pps_pkg::entry_type            rd_data;

   // Working values
   logic                          table_full;
   logic                          burst_zero;
   logic                          eligible;
   logic [pps_pkg::BURST_W-1:0]   new_rem;
   logic                          done_now;
   logic [IW+5:0]                 task_num_wide;

   pps_ram #(
      .WIDTH ($bits(pps_pkg::entry_type)),
      .DEPTH (pps_pkg::MAX_TASKS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign table_full    = (entry_count_ff == CW'(pps_pkg::MAX_TASKS));
   assign burst_zero    = (burst_length == '0);
   assign eligible      = !done_ff[cmp_idx_ff] && (TW'(rd_data.arrival) <= time_ff);
   assign new_rem       = (best_ff.remaining == '0) ? '0 :
                          best_ff.remaining - pps_pkg::BURST_W'(1);
   assign done_now      = found_ff && (new_rem == '0);
   assign task_num_wide = (IW+6)'(best_idx_ff) + (IW+6)'(1);

   always_comb begin
      entry_count_in    = entry_count_ff;
      finished_count_in = finished_count_ff;
      time_in           = time_ff;
      done_in           = done_ff;
      cmp_valid_in      = 1'b0;
      found_in          = found_ff;
      scan_idx_in       = scan_idx_ff;
      cmp_idx_in        = cmp_idx_ff;
      best_idx_in       = best_idx_ff;
      best_in           = best_ff;
      res_in            = res_ff;
      wr_en             = 1'b0;
      wr_addr           = entry_count_ff[IW-1:0];
      wr_data           = '{arrival: ready_tick, remaining: burst_length,
                            priority_num: task_priority};

      // Load: append to the table unless it is full.
      if (cmd.load_en) begin
         if (!table_full) begin
            wr_en                            = 1'b1;
            done_in[entry_count_ff[IW-1:0]]  = burst_zero;
            finished_count_in = finished_count_ff + CW'(burst_zero);
            entry_count_in    = entry_count_ff + CW'(1);
         end
         res_in.running_task  = '0;
         res_in.task_finished = 1'b0;
         res_in.finish_time   = '0;
         res_in.all_done      = (finished_count_in == entry_count_in);
         res_in.load_error    = table_full;
         res_in.tick_time     = time_ff;
      end

      if (cmd.tick_start) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end

      if (cmd.scan_step) begin
         cmp_idx_in   = scan_idx_ff;
         cmp_valid_in = 1'b1;
         scan_idx_in  = scan_idx_ff + IW'(1);
      end

      // One comparator: the entry read last cycle against the best so far.
      if (cmp_valid_ff && eligible &&
          (!found_ff || (rd_data.priority_num < best_ff.priority_num))) begin
         found_in    = 1'b1;
         best_idx_in = cmp_idx_ff;
         best_in     = rd_data;
      end

      // Write-back of the chosen task and the tick's result.
      if (cmd.update_en) begin
         if (found_ff) begin
            wr_en   = 1'b1;
            wr_addr = best_idx_ff;
            wr_data = '{arrival: best_ff.arrival, remaining: new_rem,
                        priority_num: best_ff.priority_num};
         end
         if (done_now) begin
            done_in[best_idx_ff] = 1'b1;
            finished_count_in    = finished_count_ff + CW'(1);
         end
         time_in              = pps_pkg::sat_inc(time_ff);
         res_in.running_task  = found_ff ? task_num_wide[pps_pkg::TASK_NUM_W-1:0] : '0;
         res_in.task_finished = done_now;
         res_in.finish_time   = done_now ? pps_pkg::sat_inc(time_ff) : '0;
         res_in.all_done      = (finished_count_in == entry_count_ff);
         res_in.load_error    = 1'b0;
         res_in.tick_time     = time_ff;
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_data_in  = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff    <= '0;
         finished_count_ff <= '0;
         time_ff           <= '0;
         done_ff           <= '0;
         cmp_valid_ff      <= 1'b0;
         found_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         entry_count_ff    <= entry_count_in;
         finished_count_ff <= finished_count_in;
         time_ff           <= time_in;
         done_ff           <= done_in;
         cmp_valid_ff      <= cmp_valid_in;
         found_ff          <= found_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.table_empty = (entry_count_ff == '0);
   assign status.scan_last   = (CW'(scan_idx_ff) == entry_count_ff - CW'(1));
   assign status.out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_payload        = rsp_data_ff;

endmodule

// File: hw/rtl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: table-based preemptive priority scheduler
// Loads task entries and, on each tick, runs the ready task with the lowest
// priority number for one time unit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   req_*     in          load a task entry (tuser 0) or advance one tick (tuser 1)
//   rsp_*     out         one result beat for every request beat
//
// A load's result is registered on acceptance and then handed over. A tick
// scans the loaded entries, or skips to write-back with an empty table: the
// task RAM has a single read port, so the scan visits one loaded entry per
// cycle, followed by the final compare, write-back and hand-over.
// Reset is synchronous; it clears the counters, the time and the done marks.
// The task RAM is not cleared, since only loaded entries are ever read.
// The result register lets the next request be accepted while a result beat
// waits on rsp_tready; that next result is held until the register frees.
//
module preemptive_priority_scheduler (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // ready_tick[15:0], burst_length[31:16],
                                   // task_priority[39:32]
   input  logic        req_tuser,  // func: 0 load, 1 tick
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // running_task[4:0], task_finished[5],
                                   // finish_time[37:6], all_done[38],
                                   // load_error[39], tick_time[71:40]
);

   pps_pkg::ctrl_cmd_type    cmd;
   pps_pkg::dp_status_type   status;
   pps_pkg::req_payload_type req_payload;
   pps_pkg::rsp_payload_type rsp_payload;

   assign req_payload = req_tdata;
   assign rsp_tdata   = rsp_payload;

   // The controller decides when a beat is taken and which phase runs next.
   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the table, counters and the result register.
   pps_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .ready_tick    (req_payload.ready_tick),
      .burst_length  (req_payload.burst_length),
      .task_priority (req_payload.task_priority),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_payload   (rsp_payload)
   );

endmodule

// File: hw/rtl/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker: port-level checks for the scheduler
// Watches the result channel for held beats and consistent result fields.
// ----------------------------------------------------------------------------
module pps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   pps_pkg::rsp_payload_type rsp;

   assign rsp = rsp_tdata;

   // A stalled result beat stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // A completion names a real task and ends one time unit after the tick.
   a_finish_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.task_finished |->
         (rsp.running_task != '0) &&
         (rsp.finish_time == pps_pkg::sat_inc(rsp.tick_time)))
      else $error("completion with wrong task or finish time");

   // Without a completion the finish time reads zero.
   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.task_finished |-> rsp.finish_time == '0)
      else $error("finish time set without completion");

   // A rejected load runs nothing.
   a_load_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.load_error |->
         (rsp.running_task == '0) && !rsp.task_finished)
      else $error("load error beat reports a running task");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/schedule_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schedule_checker: result checker for the preemptive priority scheduler
// Watches both stream channels, keeps its own copy of the task table, predicts
// the result beat for each accepted request beat and compares it field by
// field with the beats that the block delivers.
// ----------------------------------------------------------------------------
module schedule_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,  // ready_tick[15:0], burst_length[31:16],
                                   // task_priority[39:32]
   input  logic        req_tuser,  // func: 0 load, 1 tick
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,  // running_task[4:0], task_finished[5],
                                   // finish_time[37:6], all_done[38],
                                   // load_error[39], tick_time[71:40]
   output int          mismatches,
   output int          outstanding
);

   localparam int IW = pps_pkg::TASK_IDX_W;

   // Shadow task table
   logic [pps_pkg::ARRIVAL_W-1:0]  arrival_tab  [pps_pkg::MAX_TASKS];
   logic [pps_pkg::BURST_W-1:0]    remain_tab   [pps_pkg::MAX_TASKS];
   logic [pps_pkg::PRIO_W-1:0]     prio_tab     [pps_pkg::MAX_TASKS];
   logic                           done_tab     [pps_pkg::MAX_TASKS];
   logic [pps_pkg::TASK_CNT_W-1:0] loaded_count;
   logic [pps_pkg::TASK_CNT_W-1:0] retired_count;
   logic [pps_pkg::TIME_W-1:0]     sched_time;

   pps_pkg::rsp_payload_type predicted_beats[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Applies one request to the shadow table and returns the result it causes.
   function automatic pps_pkg::rsp_payload_type schedule_step(
      input logic func, input pps_pkg::req_payload_type req);
      pps_pkg::rsp_payload_type res;
      int                       i;
      logic [IW-1:0]            slot;
      logic [IW-1:0]            idx;
      logic [IW-1:0]            best;
      bit                       found;
      res           = '0;
      res.tick_time = sched_time;
      slot          = loaded_count[IW-1:0];
      if (func == pps_pkg::FUNC_LOAD) begin
         if (loaded_count < pps_pkg::MAX_TASKS) begin
            arrival_tab[slot] = req.ready_tick;
            remain_tab[slot]  = req.burst_length;
            prio_tab[slot]    = req.task_priority;
            done_tab[slot]    = (req.burst_length == '0);
            if (req.burst_length == '0)
               retired_count = retired_count + 1'b1;
            loaded_count = loaded_count + 1'b1;
         end else begin
            res.load_error = 1'b1;
         end
      end else begin
         found = 0;
         best  = '0;
         for (i = 0; i < loaded_count; i++) begin
            idx = IW'(i);
            if (!done_tab[idx] && pps_pkg::TIME_W'(arrival_tab[idx]) <= sched_time &&
                (!found || prio_tab[idx] < prio_tab[best])) begin
               found = 1;
               best  = idx;
            end
         end
         if (found) begin
            res.running_task = pps_pkg::TASK_NUM_W'(best) + pps_pkg::TASK_NUM_W'(1);
            if (remain_tab[best] != '0)
               remain_tab[best] = remain_tab[best] - 1'b1;
            if (remain_tab[best] == '0) begin
               done_tab[best]    = 1'b1;
               retired_count     = retired_count + 1'b1;
               res.task_finished = 1'b1;
               res.finish_time   = (sched_time == '1) ? sched_time : sched_time + 1'b1;
            end
         end
         sched_time = (sched_time == '1) ? sched_time : sched_time + 1'b1;
      end
      res.all_done = (retired_count == loaded_count);
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      pps_pkg::rsp_payload_type want;
      pps_pkg::rsp_payload_type got;
      if (reset) begin
         done_tab      = '{default: 1'b0};
         loaded_count  = '0;
         retired_count = '0;
         sched_time    = '0;
         predicted_beats.delete();
      end else begin
         // Compare first: a result can never belong to a request taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got = pps_pkg::rsp_payload_type'(rsp_tdata);
            if (predicted_beats.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = predicted_beats.pop_front();
               check_field("running_task",  want.running_task,  got.running_task);
               check_field("task_finished", want.task_finished, got.task_finished);
               check_field("finish_time",   want.finish_time,   got.finish_time);
               check_field("all_done",      want.all_done,      got.all_done);
               check_field("load_error",    want.load_error,    got.load_error);
               check_field("tick_time",     want.tick_time,     got.tick_time);
            end
         end
         if (req_tvalid && req_tready)
            predicted_beats.push_back(schedule_step(req_tuser,
                                         pps_pkg::req_payload_type'(req_tdata)));
      end
      outstanding = predicted_beats.size();
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the preemptive priority scheduler
// Drives load and tick beats into the block, first a directed sequence and
// then a long random one, while the result channel stalls in several
// patterns. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // ready_tick[15:0], burst_length[31:16],
                             // task_priority[39:32]
   logic        req_tuser;   // func: 0 load, 1 tick
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;   // running_task[4:0], task_finished[5],
                             // finish_time[37:6], all_done[38],
                             // load_error[39], tick_time[71:40]

   int mismatches;
   int outstanding;

   // Idling controls, changed by the stimulus as it moves between phases.
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   bit hold_results      = 0;

   // The stimulus tracks the block's time itself, which is simply the number
   // of ticks sent so far, so that loaded tasks arrive in the near future.
   int ticks_sent = 0;
   int loads_sent = 0;

   preemptive_priority_scheduler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   schedule_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Safety net: a hung handshake must not keep the run alive forever.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Offers one request beat. Any idle cycles come first, with tvalid low;
   // otherwise tvalid stays high straight into the next beat, so it is never
   // dropped and raised again within the same time step.
   task automatic send_beat(input logic func, input logic [15:0] arrival,
                            input logic [15:0] burst, input logic [7:0] prio);
      pps_pkg::req_payload_type beat;
      beat.ready_tick    = arrival;
      beat.burst_length  = burst;
      beat.task_priority = prio;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      if (func == pps_pkg::FUNC_TICK)
         ticks_sent++;
      else
         loads_sent++;
   endtask

   task automatic send_tick();
      // The payload of a tick is meaningless, so it carries noise.
      send_beat(pps_pkg::FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // Result side: random stalls at the current rate, and once a long hold-off
   // while the sender keeps offering, so the block fills up and backs off.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_tready   <= 1'b0;
            hold_results  = 0;
            repeat (400) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      int        n;
      int        pick;
      int        arrival_int;
      logic [15:0] burst;
      logic [7:0]  prio;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = pps_pkg::FUNC_LOAD;
      req_tdata  = '0;
      // Reset starts high and is released at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. A tick on an empty table is idle with all tasks done.
      send_tick();
      // A zero burst retires at once and is never scheduled.
      send_beat(pps_pkg::FUNC_LOAD, 16'd0, 16'd0, 8'd0);
      send_tick();
      // The latest possible arrival: this task never becomes ready.
      send_beat(pps_pkg::FUNC_LOAD, 16'hFFFF, 16'd1, 8'd0);
      send_tick();
      // Two tasks of equal, weakest priority, then a strong one arriving later
      // that preempts them when it becomes ready at time 5.
      send_beat(pps_pkg::FUNC_LOAD, 16'd3, 16'd3, 8'hFF);
      send_beat(pps_pkg::FUNC_LOAD, 16'd3, 16'd2, 8'hFF);
      send_beat(pps_pkg::FUNC_LOAD, 16'd5, 16'd1, 8'd0);
      // Runs the tie, the preemption and all completions, then goes idle.
      repeat (8) send_tick();
      // A background task with the longest burst runs whenever nothing else is ready.
      send_beat(pps_pkg::FUNC_LOAD, 16'd0, 16'hFFFF, 8'hFF);
      send_tick();
      send_tick();

      // Random part: mostly ticks, with loads that arrive in the near future
      // and carry short bursts so that tasks keep finishing. Once the table is
      // full, loads carry random fields and must all be refused.
      for (n = 0; n < 430; n++) begin
         if (n == 0)
            hold_results = 1;
         sender_idle_pct    = (n >= 110 && n < 220) ? 86 : (n >= 330) ? 25 : 0;
         receiver_stall_pct = (n >= 220 && n < 330) ? 86 : (n >= 330) ? 25 : 0;
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            if (loads_sent < pps_pkg::MAX_TASKS) begin
               arrival_int = ticks_sent + $urandom_range(0, 25);
               burst = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
               prio  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
               send_beat(pps_pkg::FUNC_LOAD,
                         (arrival_int > 65535) ? 16'hFFFF : 16'(arrival_int),
                         burst, prio);
            end else begin
               send_beat(pps_pkg::FUNC_LOAD, 16'($urandom), 16'($urandom),
                         8'($urandom));
            end
         end else begin
            send_tick();
         end
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every predicted result, then allow for a full tick
      // scan in case something stray is still on its way.
      while (outstanding != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_ram.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_datapath.sv
hw/rtl/preemptive_priority_scheduler.sv
hw/rtl/pps_checker.sv
bench/schedule_checker.sv
bench/testbench.sv
